>>> hw/rtl/bsb_pkg.sv
// ----------------------------------------------------------------------------
// Bit stream buffer package
// Command codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int BYTE_BITS = 8;
  localparam logic [3:0] MAX_COUNT = 4'd8;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_POP    = 2'd2,
    CMD_PEEK   = 2'd3
  } bsb_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } bsb_state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic fetch;
  } bsb_ctrl_t;

  typedef struct packed {
    logic need_fetch;
  } bsb_status_t;

endpackage

>>> hw/rtl/bsb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/bsb_datapath.sv
// ----------------------------------------------------------------------------
// Bit stream buffer datapath
// Packing word, word store, read position and result registers.
// ----------------------------------------------------------------------------
module bsb_datapath #(
  parameter int WORD_DEPTH = 256,
  parameter int WORD_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bsb_pkg::bsb_ctrl_t ctrl,
  output bsb_pkg::bsb_status_t status,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic [3:0]         bit_count,
  output logic               bit_value,
  output logic               empty_res,
  output logic               overflow
);

  import bsb_pkg::*;

  localparam int AW     = $clog2(WORD_DEPTH);
  localparam int CNT_W  = $clog2(WORD_DEPTH + 1);
  localparam int FILL_W = $clog2(WORD_BITS + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int EXT_W  = WORD_BITS + BYTE_BITS;

  bsb_cmd_t             cmd_q;
  logic [7:0]           data_q;
  logic [3:0]           count_q;
  logic [WORD_BITS-1:0] pack_word;
  logic [FILL_W-1:0]    pack_fill;
  logic [CNT_W-1:0]     words_stored;
  logic [CNT_W-1:0]     read_word;
  logic [BIT_W-1:0]     read_bit;

  logic [7:0]           masked;
  logic [EXT_W-1:0]     ext;
  logic [EXT_W-1:0]     spill_ext;
  logic [SUM_W-1:0]     fill_sum;
  logic                 spill;
  logic                 full;
  logic                 has_bits;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [BIT_W-1:0]     bit_idx;

  assign masked    = data_q & ~(8'hFF >> count_q);
  assign ext       = {masked, {WORD_BITS{1'b0}}} >> pack_fill;
  assign spill_ext = {ext[BYTE_BITS-1:0], {WORD_BITS{1'b0}}};
  assign fill_sum  = SUM_W'(pack_fill) + SUM_W'(count_q);
  assign spill     = fill_sum > SUM_W'(WORD_BITS);
  assign full      = words_stored == CNT_W'(WORD_DEPTH);
  assign has_bits  = read_word < words_stored;
  assign bit_idx   = BIT_W'(WORD_BITS - 1) - read_bit;

  assign status.need_fetch = ((cmd_q == CMD_POP) || (cmd_q == CMD_PEEK)) && has_bits;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = pack_word;
    ram_re    = 1'b0;
    if (ctrl.exec) begin
      case (cmd_q)
        CMD_APPEND: begin
          ram_we    = spill && !full;
          ram_wdata = pack_word | ext[EXT_W-1 -: WORD_BITS];
        end
        CMD_FLUSH: begin
          ram_we = !full;
        end
        CMD_POP, CMD_PEEK: begin
          ram_re = has_bits;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  bsb_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(words_stored[AW-1:0]),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(read_word[AW-1:0]),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q   <= bsb_cmd_t'(cmd);
      data_q  <= data_byte;
      count_q <= (bit_count > MAX_COUNT) ? MAX_COUNT : bit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_word    <= '0;
      pack_fill    <= '0;
      words_stored <= '0;
      read_word    <= '0;
      read_bit     <= '0;
      bit_value    <= 1'b0;
      empty_res    <= 1'b0;
      overflow     <= 1'b0;
    end else if (ctrl.exec) begin
      bit_value <= 1'b0;
      empty_res <= 1'b0;
      overflow  <= 1'b0;
      case (cmd_q)
        CMD_APPEND: begin
          if (spill && full) begin
            overflow <= 1'b1;
          end else if (spill) begin
            pack_word    <= spill_ext[EXT_W-1 -: WORD_BITS];
            pack_fill    <= FILL_W'(fill_sum - SUM_W'(WORD_BITS));
            words_stored <= words_stored + 1'b1;
          end else begin
            pack_word <= pack_word | ext[EXT_W-1 -: WORD_BITS];
            pack_fill <= FILL_W'(fill_sum);
          end
        end
        CMD_FLUSH: begin
          if (full) begin
            overflow <= 1'b1;
          end else begin
            pack_word    <= '0;
            pack_fill    <= '0;
            words_stored <= words_stored + 1'b1;
            read_word    <= '0;
            read_bit     <= '0;
          end
        end
        CMD_POP, CMD_PEEK: begin
          empty_res <= !has_bits;
        end
        default: begin
          overflow <= 1'b0;
        end
      endcase
    end else if (ctrl.fetch) begin
      bit_value <= ram_rdata[bit_idx];
      if (cmd_q == CMD_POP) begin
        if (read_bit == BIT_W'(WORD_BITS - 1)) begin
          read_bit  <= '0;
          read_word <= read_word + 1'b1;
        end else begin
          read_bit <= read_bit + 1'b1;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    pack_fill <= FILL_W'(WORD_BITS))
    else $error("packing fill exceeds the word width");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    words_stored <= CNT_W'(WORD_DEPTH))
    else $error("stored word count exceeds the store depth");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    read_word <= words_stored)
    else $error("read position is beyond the stored words");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec && !full |=> !overflow)
    else $error("overflow reported while the store had room");

endmodule

>>> hw/rtl/bsb_ctrl.sv
// ----------------------------------------------------------------------------
// Bit stream buffer controller
// Sequences command capture, execution and store read, and marks results.
// ----------------------------------------------------------------------------
module bsb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output bsb_pkg::bsb_ctrl_t   ctrl,
  input  bsb_pkg::bsb_status_t status
);

  import bsb_pkg::*;

  bsb_state_t state;
  bsb_state_t state_next;
  logic       done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = status.need_fetch ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl      = '0;
    busy      = 1'b1;
    done_next = 1'b0;
    case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        ctrl.latch = start;
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
        done_next = !status.need_fetch;
      end
      ST_FETCH: begin
        ctrl.fetch = 1'b1;
        done_next  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result marked while the block is still busy");

  a_fetch_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> $past(state) == ST_EXEC)
    else $error("store read step entered without an execute step");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.latch |=> !done)
    else $error("result marked right after a command was taken");

endmodule

>>> hw/rtl/msb_first_bit_stream_buffer.sv
// ----------------------------------------------------------------------------
// MSB-first bit stream buffer
// Packs leading bits of bytes into words and reads them back bit by bit.
// ----------------------------------------------------------------------------
// A command transfer happens at a rising edge where start is high and busy
// is low; cmd, data_byte and bit_count are sampled at that edge. Append
// packs the top bit_count bits of data_byte, flush stores the partial word
// and rewinds reading, pop returns the next stored bit and advances, and
// peek returns it without advancing.
// Every command yields exactly one result, shown on bit_value, empty_res
// and overflow for the single cycle in which done is high. The receiver
// cannot stall; the result must be taken in that cycle.
// Append, flush and a read that finds the buffer empty pass through the
// execute state between transfer and result. A pop or peek that hits stored
// data also passes through the fetch state, the registered read of the word
// store RAM. A new command may be given in the cycle that done is high; while
// busy is high, the block takes no new command.
// Reset clears the packing word, the counts and the read position; the
// word store needs no clearing, since reads only reach written words.
// ----------------------------------------------------------------------------
module msb_first_bit_stream_buffer #(
  parameter int WORD_DEPTH = 256,
  parameter int WORD_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  input  logic [3:0] bit_count,
  output logic       bit_value,
  output logic       empty_res,
  output logic       overflow
);

  import bsb_pkg::*;

  bsb_ctrl_t   ctrl;
  bsb_status_t status;

  bsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl),
    .status(status)
  );

  bsb_datapath #(
    .WORD_DEPTH(WORD_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .status   (status),
    .cmd      (cmd),
    .data_byte(data_byte),
    .bit_count(bit_count),
    .bit_value(bit_value),
    .empty_res(empty_res),
    .overflow (overflow)
  );

endmodule

>>> verif/msb_first_bit_stream_buffer_tb.sv
// ----------------------------------------------------------------------------
// MSB-first bit stream buffer testbench
// A queue-fed driver issues append, flush, pop and peek commands with random
// gaps. A bit-level predictor computes the result of every accepted command.
// A monitor compares each strobed result against the oldest prediction. The
// run covers directed corner cases, random mixed traffic and framed packets,
// a phase that fills the word store, and traffic once the store is full.
// ----------------------------------------------------------------------------
module msb_first_bit_stream_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsb_pkg::*;

  localparam int WORD_DEPTH       = 256;
  localparam int WORD_BITS        = 32;
  localparam int NUM_MIXED        = 300;
  localparam int NUM_FILL_FLUSHES = WORD_DEPTH + 4;
  localparam int NUM_AFTER_FULL   = 280;
  localparam int STALL_LIMIT      = 500;
  localparam int SETTLE_CYCLES    = 8;
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    bsb_cmd_t   op;
    logic [7:0] data;
    logic [3:0] count;
    int         gap;
    bit         drain;
  } bsb_command_t;

  typedef struct {
    bsb_cmd_t op;
    logic     bit_value;
    logic     empty;
    logic     overflow;
  } bsb_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       done;
  logic [1:0] cmd = CMD_APPEND;
  logic [7:0] data_byte = 8'd0;
  logic [3:0] bit_count = 4'd0;
  logic       bit_value;
  logic       empty_res;
  logic       overflow;

  bsb_command_t command_q[$];
  bsb_result_t  result_q[$];
  bsb_command_t active_cmd;

  logic [WORD_BITS-1:0] held_words [WORD_DEPTH];
  logic [WORD_BITS-1:0] packer = '0;
  int                   packer_fill = 0;
  int                   held_count = 0;
  int                   rd_word = 0;
  int                   rd_bit = 0;

  int  accepted = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  quiet_left = 0;
  int  wait_left = 0;
  bit  armed = 1'b0;

  msb_first_bit_stream_buffer #(
    .WORD_DEPTH(WORD_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd),
    .data_byte(data_byte),
    .bit_count(bit_count),
    .bit_value(bit_value),
    .empty_res(empty_res),
    .overflow (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [3:0] draw_count();
    if ($urandom_range(0, 9) != 0) return 4'($urandom_range(1, 8));
    return ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
  endfunction

  function automatic void queue_command(bsb_cmd_t op, logic [7:0] data,
                                        logic [3:0] count, bit drain = 1'b0);
    bsb_command_t c;
    c.op    = op;
    c.data  = data;
    c.count = count;
    c.gap   = draw_gap();
    c.drain = drain;
    command_q = {command_q, c};
  endfunction

  function automatic void queue_random(int flush_pct);
    int       r;
    bsb_cmd_t op;
    r = $urandom_range(0, 99);
    if (r < flush_pct) op = CMD_FLUSH;
    else if (r < flush_pct + 45) op = CMD_APPEND;
    else if (r < flush_pct + 75) op = CMD_POP;
    else op = CMD_PEEK;
    queue_command(op, 8'($urandom), draw_count(), $urandom_range(0, 99) == 0);
  endfunction

  // A frame appends a few fragments, flushes, and reads the bits back.
  function automatic void queue_frame();
    int n_append;
    int n_read;
    n_append = $urandom_range(1, 6);
    n_read   = $urandom_range(8, 48);
    repeat (n_append) queue_command(CMD_APPEND, 8'($urandom), draw_count());
    queue_command(CMD_FLUSH, 8'($urandom), draw_count());
    repeat (n_read)
      queue_command(($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_POP,
                    8'($urandom), draw_count());
  endfunction

  function automatic void store_packer();
    held_words[held_count] = packer;
    held_count++;
    packer      = '0;
    packer_fill = 0;
  endfunction

  function automatic bsb_result_t predict_bits(bsb_command_t c);
    bsb_result_t res;
    int          n;
    res.op        = c.op;
    res.bit_value = 1'b0;
    res.empty     = 1'b0;
    res.overflow  = 1'b0;
    case (c.op)
      CMD_APPEND: begin
        n = (c.count > MAX_COUNT) ? int'(MAX_COUNT) : int'(c.count);
        if (packer_fill + n > WORD_BITS && held_count >= WORD_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (packer_fill >= WORD_BITS) store_packer();
            if (c.data[7-i]) packer[WORD_BITS-1-packer_fill] = 1'b1;
            packer_fill++;
          end
        end
      end
      CMD_FLUSH: begin
        if (held_count >= WORD_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          store_packer();
          rd_word = 0;
          rd_bit  = 0;
        end
      end
      default: begin
        if (rd_word >= held_count) begin
          res.empty = 1'b1;
        end else begin
          res.bit_value = held_words[rd_word][WORD_BITS-1-rd_bit];
          if (c.op == CMD_POP) begin
            rd_bit++;
            if (rd_bit >= WORD_BITS) begin
              rd_bit = 0;
              rd_word++;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : drive
    bit           xfer;
    bit           launch;
    bsb_command_t next_cmd;
    bsb_result_t  predicted;
    xfer   = start && !busy;
    launch = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (xfer) begin
        predicted = predict_bits(active_cmd);
        result_q  = {result_q, predicted};
        accepted++;
      end
      if (!start || xfer) begin
        if (command_q.size() != 0) begin
          if (!armed) begin
            wait_left = command_q[0].gap;
            armed     = 1'b1;
          end
          if (wait_left != 0) begin
            wait_left--;
          end else if (!command_q[0].drain || result_q.size() == 0) begin
            next_cmd = command_q.pop_front();
            armed    = 1'b0;
            launch   = 1'b1;
          end
        end
        if (launch) begin
          active_cmd <= next_cmd;
          cmd        <= next_cmd.op;
          data_byte  <= next_cmd.data;
          bit_count  <= next_cmd.count;
        end
        start <= launch;
      end
    end
  end

  always @(posedge clk) begin : check
    bsb_result_t want;
    if (!rst && done === 1'b1) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no command pending: bit=%0b empty=%0b ovf=%0b",
                   $time, bit_value, empty_res, overflow);
      end else begin
        want = result_q.pop_front();
        if (bit_value !== want.bit_value || empty_res !== want.empty ||
            overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected bit=%0b empty=%0b ovf=%0b, got bit=%0b empty=%0b ovf=%0b",
                     $time, want.op.name(), want.bit_value, want.empty, want.overflow,
                     bit_value, empty_res, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    int total;
    int mark;

    queue_command(CMD_PEEK,   8'h00, 4'd1);
    queue_command(CMD_POP,    8'hFF, 4'd8);
    queue_command(CMD_APPEND, 8'hA5, 4'd8);
    queue_command(CMD_APPEND, 8'hFF, 4'd0);
    queue_command(CMD_APPEND, 8'h80, 4'd12);
    queue_command(CMD_APPEND, 8'h3C, 4'd4);
    queue_command(CMD_APPEND, 8'h00, 4'd9);
    queue_command(CMD_APPEND, 8'hFF, 4'd15);
    queue_command(CMD_FLUSH,  8'h00, 4'd0);
    queue_command(CMD_FLUSH,  8'hFF, 4'd15);
    queue_command(CMD_PEEK,   8'h00, 4'd0);
    queue_command(CMD_POP,    8'h00, 4'd0);
    queue_command(CMD_POP,    8'h00, 4'd0);
    queue_command(CMD_PEEK,   8'h00, 4'd0);
    queue_command(CMD_APPEND, 8'hFF, 4'd8);
    queue_command(CMD_APPEND, 8'h01, 4'd1);
    queue_command(CMD_APPEND, 8'h7E, 4'd7);
    queue_command(CMD_POP,    8'h55, 4'd3);
    queue_command(CMD_FLUSH,  8'hAA, 4'd5);
    queue_command(CMD_POP,    8'h00, 4'd0);
    queue_command(CMD_PEEK,   8'h00, 4'd0);

    mark = command_q.size();
    while (command_q.size() < mark + NUM_MIXED) begin
      if ($urandom_range(0, 2) == 0) queue_frame();
      else queue_random(6);
    end

    // Every flush stores a word until the store is full.
    queue_command(CMD_FLUSH, 8'($urandom), draw_count(), 1'b1);
    repeat (NUM_FILL_FLUSHES - 1) begin
      repeat ($urandom_range(0, 2)) queue_random(0);
      queue_command(CMD_FLUSH, 8'($urandom), draw_count());
    end

    queue_command(CMD_APPEND, 8'($urandom), draw_count(), 1'b1);
    mark = command_q.size();
    while (command_q.size() < mark + NUM_AFTER_FULL) begin
      if ($urandom_range(0, 3) == 0) queue_frame();
      else queue_random(10);
    end

    total = command_q.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (accepted < total) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
